// ===== src/smaa_pkg.sv =====
// Shared types and constants for the sensor moving-average alarm block.
// Holds item structs, status and register codes, and the sequencer states.
// No dependencies.
package smaa_pkg;

  localparam int MAX_SENSORS_DEF = 16;
  localparam int AVG_LENGTH_DEF  = 5;

  localparam int VAL_W  = 16;
  localparam int ID_W   = 16;
  localparam int FILL_W = 5;   // 0 to 16 samples
  localparam int SLOT_W = 4;   // 0 to 15

  localparam logic signed [VAL_W-1:0] HOT_LIMIT_RST  = 16'sd7680;
  localparam logic signed [VAL_W-1:0] COLD_LIMIT_RST = 16'sd2560;

  typedef enum logic [0:0] {
    KIND_MAP    = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_TAKEN   = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_HOT_LIMIT  = 1'b0,
    CFG_COLD_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_SUM,
    S_LAST,
    S_DIV
  } state_t;

  typedef struct packed {
    kind_t                    kind;
    logic [ID_W-1:0]          probe_id;
    logic [ID_W-1:0]          room_id;
    logic signed [VAL_W-1:0]  sample_value;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic [ID_W-1:0]          room_of_sensor;
    logic signed [VAL_W-1:0]  average;
    logic                     average_valid;
    logic                     too_hot;
    logic                     too_cold;
  } out_item_t;

  // One sensor's table row: mapping plus window bookkeeping
  typedef struct packed {
    logic [ID_W-1:0]          probe_id;
    logic [ID_W-1:0]          room_id;
    logic [FILL_W-1:0]        fill;
    logic [SLOT_W-1:0]        slot;
    logic signed [VAL_W-1:0]  average;
  } entry_t;

endpackage

// ===== src/smaa_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the sensor table and the sample history. No dependencies.
module smaa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/smaa_avg.sv =====
// Window average: signed sum divided by the window length, truncated toward zero.
// Three-stage pipeline using a reciprocal multiply; depends on smaa_pkg.
module smaa_avg #(
  parameter int AVG_LENGTH = smaa_pkg::AVG_LENGTH_DEF,
  parameter int SUM_W      = 21
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [SUM_W-1:0]           sum,
  output logic                              done,
  output logic signed [smaa_pkg::VAL_W-1:0] avg
);

  localparam int    VW     = smaa_pkg::VAL_W;
  localparam int    MAG_W  = SUM_W;
  // Shift wide enough that the rounded-up reciprocal is exact for every magnitude
  localparam int    SHIFT  = MAG_W + $clog2(AVG_LENGTH) + 1;
  localparam int    RCP_W  = SHIFT + 1;
  localparam longint RECIP = ((longint'(1) << SHIFT) + AVG_LENGTH - 1) / AVG_LENGTH;
  localparam int    PROD_W = MAG_W + RCP_W;

  logic [MAG_W-1:0]  mag_r;
  logic [MAG_W-1:0]  mag_nxt;
  logic              neg1_r;
  logic              neg2_r;
  logic              v1_r;
  logic              v2_r;
  logic              done_r;
  logic [PROD_W-1:0] prod_r;
  logic [VW-1:0]     quo;
  logic [VW-1:0]     avg_nxt;
  logic signed [VW-1:0] avg_r;

  assign mag_nxt = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
  assign quo     = prod_r[SHIFT +: VW];
  assign avg_nxt = neg2_r ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg1_r <= sum[SUM_W-1];
    prod_r <= PROD_W'(mag_r) * PROD_W'(RCP_W'(RECIP));
    neg2_r <= neg1_r;
    avg_r  <= $signed(avg_nxt);
  end

  assign done = done_r;
  assign avg  = avg_r;

endmodule

// ===== src/sensor_moving_average_alarm_core.sv =====
// Channel  | ports                        | handshake
// input    | start, busy, in_item         | taken when start high and busy low
// result   | out_strobe, out_item         | one-cycle strobe per item, no backpressure
// config   | cfg_we, cfg_index, cfg_wdata | written when cfg_we high
//
// Map items, and samples arriving with an empty table, give their result in the
// cycle after acceptance and never raise busy. A sample for a mapped sensor takes
// one table memory read per scanned entry up to its row; while the window is
// filling its result follows the row update, and once the window is full it also
// takes one history read per window slot, then three divider stages.
// Reset is synchronous; table and history need no clearing pass. Results cannot be
// stalled; busy stays high until the item's result is registered.
// Depends on smaa_pkg, smaa_ram and smaa_avg.
module sensor_moving_average_alarm_core #(
  parameter int MAX_SENSORS = smaa_pkg::MAX_SENSORS_DEF,
  parameter int AVG_LENGTH  = smaa_pkg::AVG_LENGTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  smaa_pkg::in_item_t              in_item,
  output logic                            out_strobe,
  output smaa_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [0:0]                      cfg_index,
  input  logic [smaa_pkg::VAL_W-1:0]      cfg_wdata
);

  localparam int VW         = smaa_pkg::VAL_W;
  localparam int IDX_W      = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CNT_W      = $clog2(MAX_SENSORS + 1);
  localparam int HIST_DEPTH = MAX_SENSORS * AVG_LENGTH;
  localparam int HA_W       = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int K_W        = (AVG_LENGTH > 1) ? $clog2(AVG_LENGTH) : 1;
  localparam int SUM_W      = VW + 1 + $clog2(AVG_LENGTH);
  localparam int ENTRY_W    = $bits(smaa_pkg::entry_t);
  localparam int FW         = smaa_pkg::FILL_W;
  localparam int SW         = smaa_pkg::SLOT_W;

  smaa_pkg::state_t    state_r, state_nxt;
  smaa_pkg::in_item_t  item_r, item_nxt;
  smaa_pkg::entry_t    entry_r, entry_nxt;
  smaa_pkg::entry_t    upd_entry;
  smaa_pkg::out_item_t out_item_r, out_item_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [K_W-1:0]      k_r, k_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]    entry_count_r, entry_count_nxt;
  logic signed [VW-1:0] hot_limit_r, hot_limit_nxt;
  logic signed [VW-1:0] cold_limit_r, cold_limit_nxt;

  logic                ent_we;
  logic [IDX_W-1:0]    ent_waddr;
  smaa_pkg::entry_t    ent_wdata;
  logic [IDX_W-1:0]    ent_raddr;
  logic [ENTRY_W-1:0]  ent_rdata_raw;
  smaa_pkg::entry_t    ent_rdata;

  logic                hist_we;
  logic [HA_W-1:0]     hist_base;
  logic [HA_W-1:0]     hist_waddr;
  logic [HA_W-1:0]     hist_raddr;
  logic [VW-1:0]       hist_rdata;

  logic                div_start;
  logic signed [SUM_W-1:0] div_sum;
  logic                div_done;
  logic signed [VW-1:0] div_avg;

  logic [FW-1:0]       fill_new;
  logic [SW-1:0]       slot_new;

  assign ent_rdata  = smaa_pkg::entry_t'(ent_rdata_raw);
  assign hist_base  = HA_W'(idx_r * AVG_LENGTH);
  assign hist_waddr = hist_base + HA_W'(entry_r.slot);
  assign hist_raddr = hist_base + HA_W'(k_r);
  assign div_sum    = acc_r + SUM_W'($signed(hist_rdata));

  // Window bookkeeping after this sample is written
  assign fill_new = (entry_r.fill < FW'(AVG_LENGTH)) ? entry_r.fill + 1'b1 : entry_r.fill;
  assign slot_new = (entry_r.slot == SW'(AVG_LENGTH - 1)) ? '0 : entry_r.slot + 1'b1;

  always_comb begin
    upd_entry      = entry_r;
    upd_entry.fill = fill_new;
    upd_entry.slot = slot_new;
  end

  smaa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SENSORS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata_raw)
  );

  smaa_ram #(
    .WIDTH (VW),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (item_r.sample_value),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  smaa_avg #(
    .AVG_LENGTH (AVG_LENGTH),
    .SUM_W      (SUM_W)
  ) u_avg (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .sum   (div_sum),
    .done  (div_done),
    .avg   (div_avg)
  );

  always_comb begin
    hot_limit_nxt  = hot_limit_r;
    cold_limit_nxt = cold_limit_r;
    if (cfg_we) begin
      unique case (cfg_index)
        smaa_pkg::CFG_HOT_LIMIT:  hot_limit_nxt  = $signed(cfg_wdata);
        smaa_pkg::CFG_COLD_LIMIT: cold_limit_nxt = $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    entry_nxt       = entry_r;
    idx_nxt         = idx_r;
    k_nxt           = k_r;
    rd_vld_nxt      = 1'b0;
    acc_nxt         = acc_r;
    entry_count_nxt = entry_count_r;
    out_strobe_nxt  = 1'b0;
    out_item_nxt    = out_item_r;
    ent_we          = 1'b0;
    ent_waddr       = idx_r;
    ent_wdata       = upd_entry;
    ent_raddr       = (state_r == smaa_pkg::S_IDLE) ? '0 : idx_r + 1'b1;
    hist_we         = 1'b0;
    div_start       = 1'b0;

    unique case (state_r)
      smaa_pkg::S_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          if (in_item.kind == smaa_pkg::KIND_MAP) begin
            out_strobe_nxt = 1'b1;
            out_item_nxt   = '0;
            if (entry_count_r == CNT_W'(MAX_SENSORS)) begin
              out_item_nxt.status = smaa_pkg::ST_FULL;
            end else begin
              ent_we                      = 1'b1;
              ent_waddr                   = entry_count_r[IDX_W-1:0];
              ent_wdata                   = '0;
              ent_wdata.probe_id          = in_item.probe_id;
              ent_wdata.room_id           = in_item.room_id;
              entry_count_nxt             = entry_count_r + 1'b1;
              out_item_nxt.status         = smaa_pkg::ST_STORED;
              out_item_nxt.room_of_sensor = in_item.room_id;
            end
          end else if (entry_count_r == '0) begin
            out_strobe_nxt      = 1'b1;
            out_item_nxt        = '0;
            out_item_nxt.status = smaa_pkg::ST_UNKNOWN;
          end else begin
            // Row 0 is being read this cycle
            idx_nxt   = '0;
            state_nxt = smaa_pkg::S_SCAN;
          end
        end
      end

      smaa_pkg::S_SCAN: begin
        if (ent_rdata.probe_id == item_r.probe_id) begin
          entry_nxt = ent_rdata;
          state_nxt = smaa_pkg::S_UPDATE;
        end else if ((CNT_W'(idx_r) + CNT_W'(1)) == entry_count_r) begin
          out_strobe_nxt      = 1'b1;
          out_item_nxt        = '0;
          out_item_nxt.status = smaa_pkg::ST_UNKNOWN;
          state_nxt           = smaa_pkg::S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      smaa_pkg::S_UPDATE: begin
        hist_we   = 1'b1;
        entry_nxt = upd_entry;
        if (fill_new == FW'(AVG_LENGTH)) begin
          acc_nxt   = '0;
          k_nxt     = '0;
          state_nxt = smaa_pkg::S_SUM;
        end else begin
          ent_we                      = 1'b1;
          out_strobe_nxt              = 1'b1;
          out_item_nxt                = '0;
          out_item_nxt.status         = smaa_pkg::ST_TAKEN;
          out_item_nxt.room_of_sensor = entry_r.room_id;
          out_item_nxt.average        = entry_r.average;
          state_nxt                   = smaa_pkg::S_IDLE;
        end
      end

      smaa_pkg::S_SUM: begin
        // Issue one history read a cycle; add the previous one's data
        rd_vld_nxt = 1'b1;
        if (rd_vld_r) begin
          acc_nxt = div_sum;
        end
        k_nxt = k_r + 1'b1;
        if (k_r == K_W'(AVG_LENGTH - 1)) begin
          state_nxt = smaa_pkg::S_LAST;
        end
      end

      smaa_pkg::S_LAST: begin
        div_start = 1'b1;
        state_nxt = smaa_pkg::S_DIV;
      end

      smaa_pkg::S_DIV: begin
        if (div_done) begin
          // entry_r already holds the advanced slot and fill; the write adds the new average
          ent_we                      = 1'b1;
          ent_wdata                   = entry_r;
          ent_wdata.average           = div_avg;
          entry_nxt.average           = div_avg;
          out_strobe_nxt              = 1'b1;
          out_item_nxt.status         = smaa_pkg::ST_TAKEN;
          out_item_nxt.room_of_sensor = entry_r.room_id;
          out_item_nxt.average        = div_avg;
          out_item_nxt.average_valid  = 1'b1;
          out_item_nxt.too_hot        = (div_avg > hot_limit_r);
          out_item_nxt.too_cold       = (div_avg < cold_limit_r);
          state_nxt                   = smaa_pkg::S_IDLE;
        end
      end

      default: state_nxt = smaa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= smaa_pkg::S_IDLE;
      entry_count_r <= '0;
      out_strobe_r  <= 1'b0;
      rd_vld_r      <= 1'b0;
      hot_limit_r   <= smaa_pkg::HOT_LIMIT_RST;
      cold_limit_r  <= smaa_pkg::COLD_LIMIT_RST;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
      out_strobe_r  <= out_strobe_nxt;
      rd_vld_r      <= rd_vld_nxt;
      hot_limit_r   <= hot_limit_nxt;
      cold_limit_r  <= cold_limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    entry_r    <= entry_nxt;
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != smaa_pkg::S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> !busy)
    else $error("result strobe while an item is still in progress");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CNT_W'(MAX_SENSORS))
    else $error("entry count beyond table size");

  a_valid_only_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (!out_item_r.average_valid || out_item_r.status == smaa_pkg::ST_TAKEN))
    else $error("average flagged valid on a result that is not a sample");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy) |=> (busy || out_strobe_r))
    else $error("accepted item neither in progress nor answered");

endmodule

// ===== tb/smaa_alarm_checker.sv =====
// Watches the item, result and register ports of the moving-average alarm block,
// predicts each result and compares it with what the block produced.
// Depends on smaa_pkg.
`timescale 1ns / 100ps

module smaa_alarm_checker
  import smaa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  in_item_t             in_item,
  input  logic                 out_strobe,
  input  out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [VAL_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending
);

  localparam int SENSORS = MAX_SENSORS_DEF;
  localparam int WINDOW  = AVG_LENGTH_DEF;

  int                      mapped;
  logic [ID_W-1:0]         id_tab   [SENSORS];
  logic [ID_W-1:0]         room_tab [SENSORS];
  logic signed [VAL_W-1:0] hist     [SENSORS][WINDOW];
  int                      fill     [SENSORS];
  int                      wr_slot  [SENSORS];
  logic signed [VAL_W-1:0] avg_tab  [SENSORS];
  logic signed [VAL_W-1:0] hot_lim;
  logic signed [VAL_W-1:0] cold_lim;

  out_item_t expected_alarms[$];
  int        errors  = 0;
  int        backlog = 0;

  assign fail_count = errors;
  assign pending    = backlog;

  function automatic out_item_t predict_alarm(in_item_t it);
    out_item_t r;
    int        hit;
    int        sum;
    int        mean;
    r   = '0;
    hit = -1;
    if (it.kind == KIND_MAP) begin
      if (mapped >= SENSORS) begin
        r.status = ST_FULL;
        return r;
      end
      id_tab[mapped]   = it.probe_id;
      room_tab[mapped] = it.room_id;
      fill[mapped]     = 0;
      wr_slot[mapped]  = 0;
      avg_tab[mapped]  = '0;
      mapped++;
      r.status         = ST_STORED;
      r.room_of_sensor = it.room_id;
      return r;
    end
    // first matching entry wins, later duplicates stay hidden
    for (int p = 0; p < mapped; p++) begin
      if (hit < 0 && id_tab[p] == it.probe_id) hit = p;
    end
    if (hit < 0) begin
      r.status = ST_UNKNOWN;
      return r;
    end
    hist[hit][wr_slot[hit]] = it.sample_value;
    wr_slot[hit] = (wr_slot[hit] + 1) % WINDOW;
    if (fill[hit] < WINDOW) fill[hit]++;
    r.status         = ST_TAKEN;
    r.room_of_sensor = room_tab[hit];
    if (fill[hit] >= WINDOW) begin
      sum = 0;
      for (int k = 0; k < WINDOW; k++) sum += hist[hit][k];
      mean = sum / WINDOW;   // truncates toward zero
      avg_tab[hit]    = mean[VAL_W-1:0];
      r.average_valid = 1'b1;
      r.too_hot       = mean > hot_lim;
      r.too_cold      = mean < cold_lim;
    end
    r.average = avg_tab[hit];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      mapped   = 0;
      hot_lim  = HOT_LIMIT_RST;
      cold_lim = COLD_LIMIT_RST;
      for (int p = 0; p < SENSORS; p++) begin
        fill[p]    = 0;
        wr_slot[p] = 0;
        avg_tab[p] = '0;
      end
      expected_alarms.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_HOT_LIMIT:  hot_lim  = cfg_wdata;
          CFG_COLD_LIMIT: cold_lim = cfg_wdata;
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (expected_alarms.size() == 0) begin
          $error("result with no item outstanding: %p", out_item);
          errors++;
        end else begin
          want = expected_alarms.pop_front();
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            errors++;
          end
          if (out_item.room_of_sensor !== want.room_of_sensor) begin
            $error("room_of_sensor: expected %0d, got %0d",
                   want.room_of_sensor, out_item.room_of_sensor);
            errors++;
          end
          if (out_item.average !== want.average) begin
            $error("average: expected %0d, got %0d", want.average, out_item.average);
            errors++;
          end
          if (out_item.average_valid !== want.average_valid) begin
            $error("average_valid: expected %0d, got %0d",
                   want.average_valid, out_item.average_valid);
            errors++;
          end
          if (out_item.too_hot !== want.too_hot) begin
            $error("too_hot: expected %0d, got %0d", want.too_hot, out_item.too_hot);
            errors++;
          end
          if (out_item.too_cold !== want.too_cold) begin
            $error("too_cold: expected %0d, got %0d", want.too_cold, out_item.too_cold);
            errors++;
          end
        end
      end
      if (start && !busy) expected_alarms.push_back(predict_alarm(in_item));
    end
    backlog = expected_alarms.size();
  end

endmodule

// ===== tb/sensor_moving_average_alarm_core_test.sv =====
// Top of the moving-average alarm testbench: clock, reset, items and limit writes.
// Checking sits in smaa_alarm_checker; depends on smaa_pkg and the block itself.
`timescale 1ns / 100ps

module sensor_moving_average_alarm_core_test;
  import smaa_pkg::*;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  in_item_t            in_item   = '0;
  logic                cfg_we    = 1'b0;
  logic [0:0]          cfg_index = '0;
  logic [VAL_W-1:0]    cfg_wdata = '0;
  logic                busy;
  logic                out_strobe;
  out_item_t           out_item;
  int                  fails;
  int                  outstanding;

  logic [ID_W-1:0]         id_list [MAX_SENSORS_DEF];
  logic signed [VAL_W-1:0] lim_hot  = HOT_LIMIT_RST;
  logic signed [VAL_W-1:0] lim_cold = COLD_LIMIT_RST;
  bit                      idling   = 1'b1;

  sensor_moving_average_alarm_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  smaa_alarm_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fails),
    .pending    (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic in_item_t make_item(kind_t k, logic [ID_W-1:0] sid,
                                         logic [ID_W-1:0] rid, logic [VAL_W-1:0] val);
    in_item_t it;
    it.kind         = k;
    it.probe_id     = sid;
    it.room_id      = rid;
    it.sample_value = val;
    return it;
  endfunction

  function automatic logic [VAL_W-1:0] near_limit(logic signed [VAL_W-1:0] lim);
    int v;
    v = int'(lim) + int'($urandom_range(0, 6)) - 3;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] draw_sample();
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2: return near_limit(lim_hot);
      3, 4, 5: return near_limit(lim_cold);
      6, 7:    return 16'($urandom());
      8:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'(int'($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  function automatic logic [ID_W-1:0] unlisted_id();
    logic [ID_W-1:0] cand;
    bit              clash;
    do begin
      cand  = 16'($urandom());
      clash = 1'b0;
      foreach (id_list[p]) if (id_list[p] == cand) clash = 1'b1;
    end while (clash);
    return cand;
  endfunction

  // Hold the item until the block takes it, then maybe idle for a burst.
  task automatic apply_item(input in_item_t it);
    logic      was_free;
    logic [63:0] raw;
    start   <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      was_free = !busy;
      @(posedge clk);
    end while (!was_free);
    if (idling && $urandom_range(0, 3) == 0) begin
      raw      = {$urandom(), $urandom()};
      start   <= 1'b0;
      in_item <= raw[$bits(in_item_t)-1:0];
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Drop start and wait until every outstanding result has come back.
  task automatic settle();
    int waited;
    start  <= 1'b0;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while ((outstanding != 0 || busy) && waited < 2000);
    @(posedge clk);
  endtask

  task automatic write_limits(input logic [VAL_W-1:0] hot, input logic [VAL_W-1:0] cold);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HOT_LIMIT;
    cfg_wdata <= hot;
    @(posedge clk);
    cfg_index <= CFG_COLD_LIMIT;
    cfg_wdata <= cold;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    in_item_t    it;
    logic [63:0] raw;
    int          pick;
    int          pos;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // sample while the table is still empty
    apply_item(make_item(KIND_SAMPLE, 16'h1234, 16'h0, 16'h0));

    id_list[0] = 16'h0000;
    id_list[1] = 16'hFFFF;
    for (int p = 2; p < MAX_SENSORS_DEF; p++) id_list[p] = 16'($urandom_range(1, 65534));
    id_list[9] = id_list[3];   // duplicate id, never matched
    apply_item(make_item(KIND_MAP, id_list[0], 16'hFFFF, 16'h7FFF));
    apply_item(make_item(KIND_MAP, id_list[1], 16'h0000, 16'h8000));
    for (int p = 2; p < MAX_SENSORS_DEF; p++)
      apply_item(make_item(KIND_MAP, id_list[p], 16'($urandom()), 16'($urandom())));

    // table full, then an id nobody mapped
    apply_item(make_item(KIND_MAP, 16'($urandom()), 16'($urandom()), 16'h0));
    apply_item(make_item(KIND_SAMPLE, unlisted_id(), 16'h0, 16'h0100));

    // fill one window at the top of the range
    repeat (AVG_LENGTH_DEF) apply_item(make_item(KIND_SAMPLE, id_list[0], 16'h0, 16'h7FFF));

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      if (phase != 0) begin
        case (phase)
          1: begin lim_hot = 16'sh7FFF; lim_cold = 16'sh8000; end
          2: begin lim_hot = 16'sh8000; lim_cold = 16'sh7FFF; end
          3: begin lim_hot = 16'sh0000; lim_cold = 16'sh0000; end
          4: begin lim_hot = HOT_LIMIT_RST; lim_cold = COLD_LIMIT_RST; end
          5: begin lim_hot = 16'sd256; lim_cold = -16'sd256; end
          default: begin
            lim_hot  = 16'($urandom());
            lim_cold = 16'($urandom());
          end
        endcase
        write_limits(lim_hot, lim_cold);
      end
      idling = (phase != 7);
      repeat (118) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          pos = ($urandom_range(0, 4) == 0) ? MAX_SENSORS_DEF - 1
                                            : $urandom_range(0, MAX_SENSORS_DEF - 1);
          it  = make_item(KIND_SAMPLE, id_list[pos], 16'($urandom()), draw_sample());
        end else if (pick < 88) begin
          it = make_item(KIND_SAMPLE, unlisted_id(), 16'($urandom()), draw_sample());
        end else if (pick < 94) begin
          it = make_item(KIND_MAP, 16'($urandom()), 16'($urandom()), 16'($urandom()));
        end else begin
          raw = {$urandom(), $urandom()};
          it  = raw[$bits(in_item_t)-1:0];
        end
        apply_item(it);
      end
    end

    settle();
    repeat (30) @(posedge clk);
    @(negedge clk);
    if (outstanding != 0) $error("%0d results never arrived", outstanding);
    if (fails == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
